// ===== sv/mcc_pkg.sv =====
package mcc_pkg;

   localparam int MAX_AMOUNT = 64;
   localparam int MAX_DENOMS = 16;

   localparam int VAL_W   = 16;
   localparam int COUNT_W = 7;
   localparam int AMT_W   = $clog2(MAX_AMOUNT + 1);
   localparam int DIDX_W  = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
   localparam int DCNT_W  = $clog2(MAX_DENOMS + 1);
   localparam int ENTRY_W = COUNT_W + DIDX_W;
   localparam int RSP_W   = 24;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_SOLVE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_COIN    = 2'd0,
      ST_UNREACH = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic start;
      logic issue;
      logic write;
      logic bt_read;
      logic bt_emit;
      logic report;
   } cmd_type;

   typedef struct packed {
      logic value_zero;
      logic value_big;
      logic count_zero;
      logic last_idx;
      logic a_done;
      logic unreachable;
      logic bt_last;
      logic out_free;
   } stat_type;

endpackage

// ===== sv/mcc_ram.sv =====
module mcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              we,
   input  logic [$clog2(DEPTH)-1:0]          waddr,
   input  logic [WIDTH-1:0]                  wdata,
   input  logic [$clog2(DEPTH)-1:0]          raddr,
   output logic [WIDTH-1:0]                  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/mcc_ctrl.sv =====
module mcc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          opcode,
   input  mcc_pkg::stat_type   stat,
   output mcc_pkg::cmd_type    cmd
);
   import mcc_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_ISSUE   = 7'b0000010,
      S_FINISH  = 7'b0000100,
      S_WRITE   = 7'b0001000,
      S_BT_READ = 7'b0010000,
      S_BT_EMIT = 7'b0100000,
      S_REPORT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (opcode)
                  OP_LOAD:  cmd.load = 1'b1;
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_SOLVE: begin
                     cmd.start = 1'b1;
                     if (stat.value_zero || stat.value_big || stat.count_zero) begin
                        state_in = S_REPORT;
                     end else begin
                        state_in = S_ISSUE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
            if (stat.last_idx) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            if (!stat.a_done) begin
               state_in = S_ISSUE;
            end else if (stat.unreachable) begin
               state_in = S_REPORT;
            end else begin
               state_in = S_BT_READ;
            end
         end
         S_BT_READ: begin
            cmd.bt_read = 1'b1;
            state_in    = S_BT_EMIT;
         end
         S_BT_EMIT: begin
            // keep the table read on the current remainder while stalled
            cmd.bt_read = 1'b1;
            if (stat.out_free) begin
               cmd.bt_emit = 1'b1;
               state_in    = stat.bt_last ? S_IDLE : S_BT_READ;
            end
         end
         S_REPORT: begin
            if (stat.out_free) begin
               cmd.report = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/mcc_datapath.sv =====
module mcc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mcc_pkg::VAL_W-1:0]     value,
   input  mcc_pkg::cmd_type              cmd,
   output mcc_pkg::stat_type             stat,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mcc_pkg::RSP_W-1:0]     rsp_tdata,
   output logic [1:0]                    rsp_tuser,
   output logic                          rsp_tlast
);
   import mcc_pkg::*;

   logic [VAL_W-1:0]   denom_ff [MAX_DENOMS];
   logic [DCNT_W-1:0]  count_ff;
   logic [AMT_W-1:0]   amount_ff;
   logic [AMT_W-1:0]   a_ff;
   logic [AMT_W-1:0]   rem_ff;
   logic [DIDX_W-1:0]  idx_ff;
   logic [COUNT_W-1:0] best_ff;
   logic [VAL_W-1:0]   best_val_ff;
   logic [DIDX_W-1:0]  best_idx_ff;
   logic [COUNT_W-1:0] total_ff;
   logic [1:0]         rep_status_ff;

   logic               s_valid_ff;
   logic               s_prevzero_ff;
   logic [VAL_W-1:0]   s_d_ff;
   logic [DIDX_W-1:0]  s_idx_ff;

   logic               out_valid_ff;
   logic [1:0]         out_status_ff;
   logic [COUNT_W-1:0] out_count_ff;
   logic [VAL_W-1:0]   out_coin_ff;
   logic               out_last_ff;

   logic [DIDX_W-1:0]  denom_addr;
   logic [VAL_W-1:0]   d;
   logic               d_ok;
   logic [AMT_W-1:0]   prev;
   logic [COUNT_W-1:0] rd_count;
   logic [DIDX_W-1:0]  rd_idx;
   logic [COUNT_W-1:0] m;
   logic [COUNT_W-1:0] c;
   logic               better;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [AMT_W-1:0]   ram_raddr;

   mcc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_AMOUNT + 1)
   ) u_table (
      .clock (clock),
      .we    (cmd.write),
      .waddr (a_ff),
      .wdata ({best_idx_ff, best_ff}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_count = ram_rdata[COUNT_W-1:0];
   assign rd_idx   = ram_rdata[ENTRY_W-1:COUNT_W];

   always_comb begin
      denom_addr = cmd.bt_read ? rd_idx : idx_ff;
      d          = denom_ff[denom_addr];
      d_ok       = (d != '0) && (d <= VAL_W'(a_ff));
      prev       = a_ff - d[AMT_W-1:0];
      ram_raddr  = cmd.bt_read ? rem_ff : prev;
      m          = s_prevzero_ff ? '0 : rd_count;
      c          = m + COUNT_W'(1);
      better     = s_valid_ff && (s_prevzero_ff || (rd_count != '0)) &&
                   ((best_ff == '0) || (c < best_ff) ||
                    ((c == best_ff) && (s_d_ff < best_val_ff)));
   end

   always_comb begin
      stat.value_zero  = (value == '0);
      stat.value_big   = (value > VAL_W'(MAX_AMOUNT));
      stat.count_zero  = (count_ff == '0);
      stat.last_idx    = ((DCNT_W'(idx_ff) + DCNT_W'(1)) == count_ff);
      stat.a_done      = (a_ff == amount_ff);
      stat.unreachable = (best_ff == '0);
      stat.bt_last     = (VAL_W'(rem_ff) == d);
      stat.out_free    = !out_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load && (value != '0) && (count_ff < DCNT_W'(MAX_DENOMS))) begin
         denom_ff[count_ff[DIDX_W-1:0]] <= value;
      end
      if (cmd.start) begin
         amount_ff     <= value[AMT_W-1:0];
         rem_ff        <= value[AMT_W-1:0];
         a_ff          <= AMT_W'(1);
         idx_ff        <= '0;
         rep_status_ff <= (value > VAL_W'(MAX_AMOUNT)) ? ST_RANGE : ST_UNREACH;
      end
      if (cmd.issue) begin
         s_prevzero_ff <= (prev == '0);
         s_d_ff        <= d;
         s_idx_ff      <= idx_ff;
         idx_ff        <= idx_ff + DIDX_W'(1);
      end
      if (better) begin
         best_ff     <= c;
         best_val_ff <= s_d_ff;
         best_idx_ff <= s_idx_ff;
      end
      if (cmd.start || cmd.write) begin
         best_ff <= '0;
      end
      if (cmd.write) begin
         total_ff <= best_ff;
         a_ff     <= a_ff + AMT_W'(1);
         idx_ff   <= '0;
      end
      if (cmd.bt_emit) begin
         rem_ff        <= rem_ff - d[AMT_W-1:0];
         out_status_ff <= ST_COIN;
         out_count_ff  <= total_ff;
         out_coin_ff   <= d;
         out_last_ff   <= (VAL_W'(rem_ff) == d);
      end
      if (cmd.report) begin
         out_status_ff <= rep_status_ff;
         out_count_ff  <= '0;
         out_coin_ff   <= '0;
         out_last_ff   <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            count_ff <= '0;
         end else if (cmd.load && (value != '0) && (count_ff < DCNT_W'(MAX_DENOMS))) begin
            count_ff <= count_ff + DCNT_W'(1);
         end
         s_valid_ff <= cmd.issue && d_ok;
         if (cmd.bt_emit || cmd.report) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_W - COUNT_W - VAL_W){1'b0}}, out_coin_ff, out_count_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sv/min_coin_change_solver.sv =====
// Minimum coin change solver. Send items with req_tuser as the opcode: load a
// denomination (zero and loads beyond the table size are dropped), solve for the
// amount in req_tdata, or clear the denominations. A solve streams one result
// per coin on rsp with the total coin count, tlast on the final coin; a zero or
// unreachable amount gives a single status 1 result, an amount above the table
// limit a single status 2 result. A solve of amount A with N loaded denominations
// fills the count table for amounts 1 to A, reading one entry per denomination
// through the single read port of the table memory before writing each amount's
// entry, then backtracks one coin per result, holding while rsp is stalled. The
// table memory needs no clearing after reset.
module min_coin_change_solver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mcc_pkg::VAL_W-1:0]     req_tdata,  // value
   input  logic [1:0]                    req_tuser,  // opcode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mcc_pkg::RSP_W-1:0]     rsp_tdata,  // coin_count, coin_value
   output logic [1:0]                    rsp_tuser,  // status
   output logic                          rsp_tlast
);
   import mcc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .opcode     (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   mcc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .value      (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_status_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_COIN) |-> rsp_tlast && (rsp_tdata == '0))
      else $error("non-coin result not final or not zero");

   a_coin_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_COIN) |->
         (rsp_tdata[COUNT_W-1:0] != '0) && (rsp_tdata[COUNT_W+VAL_W-1:COUNT_W] != '0))
      else $error("coin result with zero count or value");

   a_no_bad_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == ST_COIN) || (rsp_tuser == ST_UNREACH) ||
                      (rsp_tuser == ST_RANGE)))
      else $error("reserved status code on output");

   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_SOLVE) |=> !req_tready)
      else $error("solve accepted without leaving idle");

endmodule
